[rtl/core/xenc_pkg.sv]
package xenc_pkg;

    typedef struct packed {
        logic [5:0]         mode;
        logic [2:0]         reg_a;
        logic [2:0]         reg_b;
        logic signed [31:0] displacement;
        logic [63:0]        immediate;
    } in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic [1:0] error_code;
    } out_t;

    localparam int unsigned MaxBytes = 15;
    localparam int unsigned CntW     = $clog2(MaxBytes + 1);

    typedef logic [MaxBytes-1:0][7:0] byte_buf_t;

    typedef struct packed {
        byte_buf_t       bytes;
        logic [CntW-1:0] count;
        logic [1:0]      err;
    } enc_t;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV       = 2'd1;
    localparam logic [1:0] ERR_IMUL_WIDE = 2'd2;

    localparam logic [5:0] MODE_CMP_RR      = 6'd0;
    localparam logic [5:0] MODE_CMP_RAX_IMM = 6'd1;
    localparam logic [5:0] MODE_PUSH        = 6'd2;
    localparam logic [5:0] MODE_POP         = 6'd3;
    localparam logic [5:0] MODE_ADD_RR      = 6'd4;
    localparam logic [5:0] MODE_SUB_RR      = 6'd5;
    localparam logic [5:0] MODE_IMUL_RR     = 6'd6;
    localparam logic [5:0] MODE_DIV_RR      = 6'd7;
    localparam logic [5:0] MODE_XOR_RR      = 6'd8;
    localparam logic [5:0] MODE_ADD_RI      = 6'd9;
    localparam logic [5:0] MODE_SUB_RI      = 6'd10;
    localparam logic [5:0] MODE_IMUL_RI     = 6'd11;
    localparam logic [5:0] MODE_DIV_RI      = 6'd12;
    localparam logic [5:0] MODE_MOV_RR      = 6'd13;
    localparam logic [5:0] MODE_MOV_RI32    = 6'd14;
    localparam logic [5:0] MODE_MOV_RI64    = 6'd15;
    localparam logic [5:0] MODE_MOV_RM      = 6'd16;
    localparam logic [5:0] MODE_MOV_MI32    = 6'd17;
    localparam logic [5:0] MODE_MOV_MI64    = 6'd18;
    localparam logic [5:0] MODE_MOV_MR      = 6'd19;
    localparam logic [5:0] MODE_INC         = 6'd20;
    localparam logic [5:0] MODE_DEC         = 6'd21;
    localparam logic [5:0] MODE_NOT         = 6'd22;
    localparam logic [5:0] MODE_NEG         = 6'd23;
    localparam logic [5:0] MODE_CALL        = 6'd24;
    localparam logic [5:0] MODE_INT         = 6'd25;
    localparam logic [5:0] MODE_LEAVE       = 6'd26;
    localparam logic [5:0] MODE_RET         = 6'd27;
    localparam logic [5:0] MODE_JMP         = 6'd28;
    localparam logic [5:0] MODE_JCC_FIRST   = 6'd29;
    localparam logic [5:0] MODE_JCC_LAST    = 6'd40;

    localparam logic [7:0] OP_REX_W       = 8'h48;
    localparam logic [7:0] OP_CMP_RR      = 8'h39;
    localparam logic [7:0] OP_CMP_RAX_IMM = 8'h3D;
    localparam logic [7:0] OP_PUSH        = 8'h50;
    localparam logic [7:0] OP_POP         = 8'h58;
    localparam logic [7:0] OP_ADD_RR      = 8'h01;
    localparam logic [7:0] OP_SUB_RR      = 8'h29;
    localparam logic [7:0] OP_ESCAPE      = 8'h0F;
    localparam logic [7:0] OP_IMUL_RR     = 8'hAF;
    localparam logic [7:0] OP_XOR_RR      = 8'h31;
    localparam logic [7:0] OP_GRP1_IMM32  = 8'h81;
    localparam logic [7:0] OP_IMUL_IMM8   = 8'h6B;
    localparam logic [7:0] OP_MOV_RM_R    = 8'h89;
    localparam logic [7:0] OP_MOV_R_RM    = 8'h8B;
    localparam logic [7:0] OP_MOV_R_IMM   = 8'hB8;
    localparam logic [7:0] OP_MOV_RM_IMM  = 8'hC7;
    localparam logic [7:0] OP_GRP5        = 8'hFF;
    localparam logic [7:0] OP_GRP3        = 8'hF7;
    localparam logic [7:0] OP_CALL        = 8'hE8;
    localparam logic [7:0] OP_INT         = 8'hCD;
    localparam logic [7:0] OP_LEAVE       = 8'hC9;
    localparam logic [7:0] OP_RET         = 8'hC3;
    localparam logic [7:0] OP_JMP         = 8'hE9;

    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP32 = 2'b10;
    localparam logic [1:0] MOD_DIRECT = 2'b11;

    function automatic logic [7:0] modrm_direct(input logic [2:0] r, input logic [2:0] rm);
        return {MOD_DIRECT, r, rm};
    endfunction

    function automatic logic [7:0] jcc_opcode(input logic [5:0] mode);
        logic [7:0] op;
        case (mode - MODE_JCC_FIRST)
            6'd0:    op = 8'h84;
            6'd1:    op = 8'h85;
            6'd2:    op = 8'h80;
            6'd3:    op = 8'h81;
            6'd4:    op = 8'h88;
            6'd5:    op = 8'h89;
            6'd6:    op = 8'h8F;
            6'd7:    op = 8'h8D;
            6'd8:    op = 8'h8C;
            6'd9:    op = 8'h8E;
            6'd10:   op = 8'h8A;
            6'd11:   op = 8'h8B;
            default: op = 8'h00;
        endcase
        return op;
    endfunction

endpackage

[rtl/core/xenc_encoder.sv]
module xenc_encoder (
    input  xenc_pkg::in_t  req,
    output xenc_pkg::enc_t enc
);

    localparam int unsigned CntW = xenc_pkg::CntW;

    logic [2:0][7:0]  head;
    logic [1:0]       head_n;
    logic             has_mrm;
    logic [7:0]       mrm;
    logic [2:0]       disp_n;
    logic [3:0]       imm_n;
    logic [1:0]       err;
    logic             known;
    logic             disp_small;
    logic [1:0]       based_mod;
    logic [2:0]       based_dn;
    logic [31:0]      disp_u;
    logic [CntW-1:0]  d_off;
    logic [CntW-1:0]  i_off;
    logic [CntW-1:0]  total;

    assign disp_u     = req.displacement;
    assign disp_small = (disp_u[31:7] == '0) || (disp_u[31:7] == '1);
    assign based_mod  = disp_small ? xenc_pkg::MOD_DISP8 : xenc_pkg::MOD_DISP32;
    assign based_dn   = disp_small ? 3'd1 : 3'd4;

    always_comb begin
        head    = '0;
        head_n  = 2'd0;
        has_mrm = 1'b0;
        mrm     = 8'h00;
        disp_n  = 3'd0;
        imm_n   = 4'd0;
        err     = xenc_pkg::ERR_NONE;
        known   = 1'b1;
        case (req.mode)
            xenc_pkg::MODE_CMP_RR: begin
                head[0] = xenc_pkg::OP_CMP_RR; head_n = 2'd1;
                has_mrm = 1'b1; mrm = xenc_pkg::modrm_direct(req.reg_a, req.reg_b);
            end
            xenc_pkg::MODE_CMP_RAX_IMM: begin
                head[0] = xenc_pkg::OP_CMP_RAX_IMM; head_n = 2'd1; imm_n = 4'd4;
            end
            xenc_pkg::MODE_PUSH: begin
                head[0] = xenc_pkg::OP_PUSH + {5'd0, req.reg_a}; head_n = 2'd1;
            end
            xenc_pkg::MODE_POP: begin
                head[0] = xenc_pkg::OP_POP + {5'd0, req.reg_a}; head_n = 2'd1;
            end
            xenc_pkg::MODE_ADD_RR, xenc_pkg::MODE_SUB_RR, xenc_pkg::MODE_XOR_RR,
            xenc_pkg::MODE_MOV_RR: begin
                head[0] = xenc_pkg::OP_REX_W; head_n = 2'd2;
                case (req.mode)
                    xenc_pkg::MODE_ADD_RR: head[1] = xenc_pkg::OP_ADD_RR;
                    xenc_pkg::MODE_SUB_RR: head[1] = xenc_pkg::OP_SUB_RR;
                    xenc_pkg::MODE_XOR_RR: head[1] = xenc_pkg::OP_XOR_RR;
                    default:               head[1] = xenc_pkg::OP_MOV_RM_R;
                endcase
                has_mrm = 1'b1; mrm = xenc_pkg::modrm_direct(req.reg_b, req.reg_a);
            end
            xenc_pkg::MODE_IMUL_RR: begin
                head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_ESCAPE;
                head[2] = xenc_pkg::OP_IMUL_RR; head_n = 2'd3;
                has_mrm = 1'b1; mrm = xenc_pkg::modrm_direct(req.reg_a, req.reg_b);
            end
            xenc_pkg::MODE_DIV_RR, xenc_pkg::MODE_DIV_RI: begin
                err = xenc_pkg::ERR_DIV;
            end
            xenc_pkg::MODE_ADD_RI, xenc_pkg::MODE_SUB_RI: begin
                head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_GRP1_IMM32;
                head_n = 2'd2; has_mrm = 1'b1; imm_n = 4'd4;
                mrm = xenc_pkg::modrm_direct(
                    (req.mode == xenc_pkg::MODE_ADD_RI) ? 3'd0 : 3'd5, req.reg_a);
            end
            xenc_pkg::MODE_IMUL_RI: begin
                if (req.immediate[31:8] != '0) begin
                    err = xenc_pkg::ERR_IMUL_WIDE;
                end else begin
                    head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_IMUL_IMM8;
                    head_n = 2'd2; imm_n = 4'd1;
                    has_mrm = 1'b1; mrm = xenc_pkg::modrm_direct(req.reg_a, req.reg_a);
                end
            end
            xenc_pkg::MODE_MOV_RI32: begin
                head[0] = xenc_pkg::OP_MOV_R_IMM + {5'd0, req.reg_a};
                head_n = 2'd1; imm_n = 4'd4;
            end
            xenc_pkg::MODE_MOV_RI64: begin
                head[0] = xenc_pkg::OP_REX_W;
                head[1] = xenc_pkg::OP_MOV_R_IMM + {5'd0, req.reg_a};
                head_n = 2'd2; imm_n = 4'd8;
            end
            xenc_pkg::MODE_MOV_RM: begin
                head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_MOV_R_RM; head_n = 2'd2;
                has_mrm = 1'b1; mrm = {based_mod, req.reg_a, req.reg_b}; disp_n = based_dn;
            end
            xenc_pkg::MODE_MOV_MI32: begin
                head[0] = xenc_pkg::OP_MOV_RM_IMM; head_n = 2'd1; imm_n = 4'd4;
                has_mrm = 1'b1; mrm = {based_mod, 3'd0, req.reg_a}; disp_n = based_dn;
            end
            xenc_pkg::MODE_MOV_MI64: begin
                head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_MOV_RM_IMM;
                head_n = 2'd2; imm_n = 4'd8;
                has_mrm = 1'b1; mrm = {based_mod, 3'd0, req.reg_a}; disp_n = based_dn;
            end
            xenc_pkg::MODE_MOV_MR: begin
                head[0] = xenc_pkg::OP_REX_W; head[1] = xenc_pkg::OP_MOV_RM_R; head_n = 2'd2;
                has_mrm = 1'b1; mrm = {based_mod, req.reg_b, req.reg_a}; disp_n = based_dn;
            end
            xenc_pkg::MODE_INC, xenc_pkg::MODE_DEC: begin
                head[0] = xenc_pkg::OP_GRP5; head_n = 2'd1; has_mrm = 1'b1;
                mrm = xenc_pkg::modrm_direct(
                    (req.mode == xenc_pkg::MODE_INC) ? 3'd0 : 3'd1, req.reg_a);
            end
            xenc_pkg::MODE_NOT, xenc_pkg::MODE_NEG: begin
                head[0] = xenc_pkg::OP_GRP3; head_n = 2'd1; has_mrm = 1'b1;
                mrm = xenc_pkg::modrm_direct(
                    (req.mode == xenc_pkg::MODE_NOT) ? 3'd2 : 3'd3, req.reg_a);
            end
            xenc_pkg::MODE_CALL: begin
                head[0] = xenc_pkg::OP_CALL; head_n = 2'd1; disp_n = 3'd4;
            end
            xenc_pkg::MODE_INT: begin
                head[0] = xenc_pkg::OP_INT; head_n = 2'd1; imm_n = 4'd1;
            end
            xenc_pkg::MODE_LEAVE: begin
                head[0] = xenc_pkg::OP_LEAVE; head_n = 2'd1;
            end
            xenc_pkg::MODE_RET: begin
                head[0] = xenc_pkg::OP_RET; head_n = 2'd1;
            end
            xenc_pkg::MODE_JMP: begin
                head[0] = xenc_pkg::OP_JMP; head_n = 2'd1; disp_n = 3'd4;
            end
            default: begin
                if (req.mode >= xenc_pkg::MODE_JCC_FIRST &&
                    req.mode <= xenc_pkg::MODE_JCC_LAST) begin
                    head[0] = xenc_pkg::OP_ESCAPE; head[1] = xenc_pkg::jcc_opcode(req.mode);
                    head_n = 2'd2; disp_n = 3'd4;
                end else begin
                    known = 1'b0;
                end
            end
        endcase
    end

    assign d_off = CntW'(head_n) + CntW'(has_mrm);
    assign i_off = d_off + CntW'(disp_n);
    assign total = i_off + CntW'(imm_n);

    always_comb begin
        enc.bytes = '0;
        for (int i = 0; i < int'(xenc_pkg::MaxBytes); i++) begin
            if (CntW'(i) < CntW'(head_n)) begin
                enc.bytes[CntW'(i)] = head[2'(i % 3)];
            end else if (has_mrm && CntW'(i) == d_off - CntW'(1)) begin
                enc.bytes[CntW'(i)] = mrm;
            end else if (CntW'(i) < i_off) begin
                enc.bytes[CntW'(i)] = 8'(disp_u >> {(CntW'(i) - d_off), 3'b000});
            end else begin
                enc.bytes[CntW'(i)] =
                    8'(req.immediate >> {3'((CntW'(i) - i_off)), 3'b000});
            end
        end
        enc.err   = err;
        enc.count = total;
        if (err != xenc_pkg::ERR_NONE) begin
            enc.bytes = '0;
            enc.count = CntW'(1);
        end else if (!known) begin
            enc.count = '0;
        end
    end

endmodule

[rtl/core/x64_instruction_encoder_unit.sv]
// x64 instruction encoder.
// Input channel s_*: one instruction request per transfer (mode, register
// codes, displacement, immediate). Output channel m_*: the machine code, one
// byte per transfer, last_byte set on the final byte. Division requests and
// a multiply immediate whose low 32 bits are 256 or more give a single
// transfer with code_byte 0, last_byte 1 and a nonzero error_code. Unknown
// modes produce nothing. The request is registered in the input register,
// then encoded into the byte buffer, from which the first byte is presented.
// Throughput: one byte per cycle while m_ready is high; an instruction
// holds the byte buffer until its last byte is taken and has 1 to 15
// bytes. The next request is taken into the input register while the
// buffer drains, and moves into the buffer in the cycle its last byte is
// taken, so bytes of consecutive instructions follow without a gap.
// Reset (aresetn low, synchronous) empties both registers; s_ready is high
// after reset. When m_ready is low the current byte holds and the input
// register fills, then s_ready drops until the buffer moves on.
module x64_instruction_encoder_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  xenc_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output xenc_pkg::out_t  m_data
);

    localparam int unsigned CntW = xenc_pkg::CntW;

    xenc_pkg::in_t        in_data_reg;
    logic                 in_valid_reg;
    xenc_pkg::enc_t       enc;
    xenc_pkg::byte_buf_t  buf_bytes_reg;
    logic [CntW-1:0]      buf_cnt_reg;
    logic [1:0]           buf_err_reg;
    logic [CntW-1:0]      idx_reg;
    logic [CntW-1:0]      idx_next;
    logic                 buf_valid_reg;
    logic                 is_last;
    logic                 buf_free;
    logic                 load;

    xenc_encoder u_encoder (
        .req (in_data_reg),
        .enc (enc)
    );

    assign is_last  = (idx_reg == buf_cnt_reg - CntW'(1));
    assign buf_free = !buf_valid_reg || (m_ready && is_last);
    assign load     = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || buf_free;
    assign idx_next = idx_reg + CntW'(1);

    assign m_valid           = buf_valid_reg;
    assign m_data.code_byte  = buf_bytes_reg[idx_reg];
    assign m_data.last_byte  = is_last;
    assign m_data.error_code = buf_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                buf_bytes_reg <= enc.bytes;
                buf_cnt_reg   <= enc.count;
                buf_err_reg   <= enc.err;
                idx_reg       <= '0;
                buf_valid_reg <= (enc.count != '0);
            end else if (buf_valid_reg && m_ready) begin
                if (is_last) begin
                    buf_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_next;
                end
            end
        end
    end

endmodule

[rtl/core/xenc_checker.sv]
module xenc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input xenc_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input xenc_pkg::out_t m_data
);

    // stalled transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output transfer changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != xenc_pkg::ERR_NONE |->
            m_data.last_byte && m_data.code_byte == 8'h00)
        else $error("error transfer not a lone zero byte");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not empty the encoder");

    // no output appears without a pending request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !$past(s_valid && s_ready) && $past(s_ready) |=> !m_valid)
        else $error("output transfer without a pending request");

endmodule

bind x64_instruction_encoder_unit xenc_checker u_xenc_checker (.*);
